// ----- src/rar_pkg.sv -----
`default_nettype none

package rar_pkg;

   // Fixed field widths of the request and response
   localparam int NumFieldWidth  = 16;
   localparam int DenFieldWidth  = 15;
   localparam int OutNumWidth    = 32;
   localparam int OutDenWidth    = 30;

   // Width used to extend values before cutting them down to a field
   localparam int ExtWidth       = 64;

   // Default operand width (numerator bits, denominator uses one less)
   localparam int DefInWidth     = 16;

   typedef struct packed {
      logic signed [NumFieldWidth-1:0] first_num;
      logic        [DenFieldWidth-1:0] first_den;
      logic signed [NumFieldWidth-1:0] second_num;
      logic        [DenFieldWidth-1:0] second_den;
   } req_type;

   typedef struct packed {
      logic signed [OutNumWidth-1:0] sum_num;
      logic        [OutDenWidth-1:0] sum_den;
      logic                          bad_input;
   } rsp_type;

endpackage : rar_pkg

`default_nettype wire

// ----- src/rational_add_reduce_top.sv -----
`default_nettype none

// Adds two signed fractions a/b + c/d and returns the sum reduced to lowest
// terms with a positive denominator. A zero denominator on either input gives
// 0/0 with bad_input set; a sum of zero gives 0/1. All divisions and products
// go through one restoring divider (one quotient bit per cycle, 2*IN_WIDTH
// bits) and one signed multiplier under a small sequencer. From acceptance
// until its result is valid a request holds the block, which runs the Euclid
// remainder steps of gcd(b,d) and gcd(|sum|,lcm), at least one step of each.
// The next request is taken once the current one has reached the output
// register; the result then waits there until the consumer takes it.
// Zero-denominator requests go straight from acceptance to the output state,
// skipping the divider and the multiplier.
module rational_add_reduce_top #(
   parameter int IN_WIDTH = rar_pkg::DefInWidth
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rar_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rar_pkg::rsp_type      rsp_data
);
   import rar_pkg::*;

   // Datapath widths
   localparam int DW = 2 * IN_WIDTH;          // divider and sum width
   localparam int MW = IN_WIDTH + 1;          // multiplier operand width
   localparam int CW = $clog2(DW + 1);        // divider step counter

   typedef enum logic [3:0] {
      S_IDLE, S_DIV, S_G1, S_G1_STEP, S_LCM, S_LCM2, S_P1, S_P2, S_SUM,
      S_G2I, S_G2, S_G2_STEP, S_Q1, S_Q2, S_OUT
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   // Operands of the request
   logic signed [MW-1:0] n1_ff, n1_in, n2_ff, n2_in;
   logic        [DW-1:0] d1_ff, d1_in, d2_ff, d2_in;

   // Euclid pair, lcm, sum and results
   logic        [DW-1:0] x_ff, x_in, y_ff, y_in, lcm_ff, lcm_in;
   logic signed [DW-1:0] sum_ff, sum_in, prod_ff, prod_in;
   logic signed [DW-1:0] num_ff, num_in;
   logic        [DW-1:0] den_ff, den_in;
   logic                 bad_ff, bad_in;

   // Shared divider registers
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] q_ff, q_in, div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // Output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Input extraction: keep IN_WIDTH numerator bits, IN_WIDTH-1 denominator bits
   logic [ExtWidth-1:0] n1_x, n2_x, d1_x, d2_x;
   logic [IN_WIDTH-1:0] n1_w, n2_w;
   logic [IN_WIDTH-2:0] d1_w, d2_w;

   assign n1_x = {{(ExtWidth-NumFieldWidth){req_data.first_num[NumFieldWidth-1]}},
                  req_data.first_num};
   assign n2_x = {{(ExtWidth-NumFieldWidth){req_data.second_num[NumFieldWidth-1]}},
                  req_data.second_num};
   assign d1_x = {{(ExtWidth-DenFieldWidth){1'b0}}, req_data.first_den};
   assign d2_x = {{(ExtWidth-DenFieldWidth){1'b0}}, req_data.second_den};
   assign n1_w = n1_x[IN_WIDTH-1:0];
   assign n2_w = n2_x[IN_WIDTH-1:0];
   assign d1_w = d1_x[IN_WIDTH-2:0];
   assign d2_w = d2_x[IN_WIDTH-2:0];

   // Divider step: shift in the next dividend bit, subtract when it fits
   logic [DW:0] div_t, div_diff;
   logic        div_ge;
   assign div_t    = {r_ff[DW-1:0], q_ff[DW-1]};
   assign div_ge   = div_t >= {1'b0, div_ff};
   assign div_diff = div_t - {1'b0, div_ff};

   // Shared signed multiplier
   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [2*MW-1:0] mul_p;
   assign mul_p = mul_a * mul_b;

   // Magnitude of the sum and output extension
   logic [DW-1:0]         mag;
   logic [ExtWidth-1:0]   num_x, den_x;
   assign mag   = sum_ff[DW-1] ? DW'(-sum_ff) : DW'(sum_ff);
   assign num_x = {{(ExtWidth-DW){num_ff[DW-1]}}, num_ff};
   assign den_x = {{(ExtWidth-DW){1'b0}}, den_ff};

   // Sequencer
   logic          start_div;
   logic [DW-1:0] dvd, dvs;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      n1_in        = n1_ff;
      n2_in        = n2_ff;
      d1_in        = d1_ff;
      d2_in        = d2_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      lcm_in       = lcm_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      bad_in       = bad_ff;
      r_in         = r_ff;
      q_in         = q_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      start_div    = 1'b0;
      dvd          = '0;
      dvs          = '0;
      mul_a        = '0;
      mul_b        = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               n1_in = {n1_w[IN_WIDTH-1], n1_w};
               n2_in = {n2_w[IN_WIDTH-1], n2_w};
               d1_in = {{(DW-IN_WIDTH+1){1'b0}}, d1_w};
               d2_in = {{(DW-IN_WIDTH+1){1'b0}}, d2_w};
               x_in  = {{(DW-IN_WIDTH+1){1'b0}}, d1_w};
               y_in  = {{(DW-IN_WIDTH+1){1'b0}}, d2_w};
               if (d1_w == '0 || d2_w == '0) begin
                  num_in   = '0;
                  den_in   = '0;
                  bad_in   = 1'b1;
                  state_in = S_OUT;
               end else begin
                  bad_in   = 1'b0;
                  state_in = S_G1;
               end
            end
         end
         S_DIV: begin
            r_in   = div_ge ? div_diff : div_t;
            q_in   = {q_ff[DW-2:0], div_ge};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               state_in = ret_ff;
            end
         end
         // gcd of the denominators
         S_G1: begin
            start_div = 1'b1;
            if (y_ff == '0) begin
               dvd    = d1_ff;
               dvs    = x_ff;
               ret_in = S_LCM;
            end else begin
               dvd    = x_ff;
               dvs    = y_ff;
               ret_in = S_G1_STEP;
            end
         end
         S_G1_STEP: begin
            x_in     = y_ff;
            y_in     = r_ff[DW-1:0];
            state_in = S_G1;
         end
         // lcm = (d1 / g) * d2
         S_LCM: begin
            mul_a    = {1'b0, q_ff[IN_WIDTH-1:0]};
            mul_b    = {1'b0, d2_ff[IN_WIDTH-1:0]};
            prod_in  = mul_p[DW-1:0];
            state_in = S_LCM2;
         end
         S_LCM2: begin
            lcm_in    = prod_ff;
            start_div = 1'b1;
            dvd       = prod_ff;
            dvs       = d1_ff;
            ret_in    = S_P1;
         end
         // scaled numerators
         S_P1: begin
            mul_a     = n1_ff;
            mul_b     = {1'b0, q_ff[IN_WIDTH-1:0]};
            prod_in   = mul_p[DW-1:0];
            start_div = 1'b1;
            dvd       = lcm_ff;
            dvs       = d2_ff;
            ret_in    = S_P2;
         end
         S_P2: begin
            sum_in   = prod_ff;
            mul_a    = n2_ff;
            mul_b    = {1'b0, q_ff[IN_WIDTH-1:0]};
            prod_in  = mul_p[DW-1:0];
            state_in = S_SUM;
         end
         S_SUM: begin
            sum_in   = sum_ff + prod_ff;
            state_in = S_G2I;
         end
         // gcd of |sum| and lcm
         S_G2I: begin
            x_in     = mag;
            y_in     = lcm_ff;
            state_in = S_G2;
         end
         S_G2: begin
            start_div = 1'b1;
            if (y_ff == '0) begin
               dvd    = mag;
               dvs    = x_ff;
               ret_in = S_Q1;
            end else begin
               dvd    = x_ff;
               dvs    = y_ff;
               ret_in = S_G2_STEP;
            end
         end
         S_G2_STEP: begin
            x_in     = y_ff;
            y_in     = r_ff[DW-1:0];
            state_in = S_G2;
         end
         // reduced numerator and denominator
         S_Q1: begin
            num_in    = sum_ff[DW-1] ? -$signed(q_ff) : $signed(q_ff);
            start_div = 1'b1;
            dvd       = lcm_ff;
            dvs       = x_ff;
            ret_in    = S_Q2;
         end
         S_Q2: begin
            den_in   = q_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.sum_num   = num_x[OutNumWidth-1:0];
               rsp_in.sum_den   = den_x[OutDenWidth-1:0];
               rsp_in.bad_input = bad_ff;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Launch the shared divider
      if (start_div) begin
         q_in     = dvd;
         r_in     = '0;
         div_in   = dvs;
         cnt_in   = CW'(DW);
         state_in = S_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n1_ff   <= n1_in;
      n2_ff   <= n2_in;
      d1_ff   <= d1_in;
      d2_ff   <= d2_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      lcm_ff  <= lcm_in;
      sum_ff  <= sum_in;
      prod_ff <= prod_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      bad_ff  <= bad_in;
      r_ff    <= r_in;
      q_ff    <= q_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff != S_IDLE)
      else $error("sequencer idle after taking a request");

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> div_ff != '0)
      else $error("divider running with zero divisor");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("response raised outside the output state");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.bad_input |-> rsp_ff.sum_num == '0 && rsp_ff.sum_den == '0)
      else $error("error response with nonzero fraction");

endmodule : rational_add_reduce_top

`default_nettype wire

// ----- bench/rational_add_reduce_top_tb.sv -----
`default_nettype none

module rational_add_reduce_top_tb;
   import rar_pkg::*;

   localparam int     RandomItems = 1530;
   localparam int     MaxWait     = 16;
   localparam int     DenMax      = (1 << DenFieldWidth) - 1;
   localparam int     DrainCycles = 2000;
   localparam longint CycleLimit  = 12_000_000;
   localparam int     MaxReports  = 40;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   typedef struct {
      req_type stim;
      bit      known;
      rsp_type want;
   } directed_case_type;

   directed_case_type directed_cases[$];
   rsp_type        pending_sums[$];
   int             fail_count   = 0;
   int             result_count = 0;
   int             bad_count    = 0;
   int             zero_count   = 0;
   longint         cycle_count  = 0;

   rational_add_reduce_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Euclid on non-negative values
   function automatic longint gcd_of(longint x, longint y);
      longint r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   // Reduced sum a/b + c/d, 0/0 with the flag on a zero denominator
   function automatic rsp_type reduced_sum(req_type r);
      longint  n1, n2, d1, d2, lcm, s, g, q, d;
      rsp_type o;
      o  = '0;
      n1 = longint'($signed(r.first_num));
      n2 = longint'($signed(r.second_num));
      d1 = longint'(r.first_den);
      d2 = longint'(r.second_den);
      if (d1 == 0 || d2 == 0) begin
         o.bad_input = 1'b1;
         return o;
      end
      lcm = d1 / gcd_of(d1, d2) * d2;
      s   = n1 * (lcm / d1) + n2 * (lcm / d2);
      // zero sum gives g = lcm, hence 0/1
      g   = gcd_of((s < 0) ? -s : s, lcm);
      q   = s / g;
      d   = lcm / g;
      o.sum_num = q[OutNumWidth-1:0];
      o.sum_den = d[OutDenWidth-1:0];
      return o;
   endfunction

   function automatic void add_case(int n1, int d1, int n2, int d2, bit known = 1'b0,
                                    int wn = 0, int wd = 0, bit wb = 1'b0);
      directed_case_type c;
      c.stim.first_num  = n1[NumFieldWidth-1:0];
      c.stim.first_den  = d1[DenFieldWidth-1:0];
      c.stim.second_num = n2[NumFieldWidth-1:0];
      c.stim.second_den = d2[DenFieldWidth-1:0];
      c.known           = known;
      c.want.sum_num    = wn;
      c.want.sum_den    = wd[OutDenWidth-1:0];
      c.want.bad_input  = wb;
      directed_cases.push_back(c);
   endfunction

   // Random request, mostly well-formed fractions of several shapes
   function automatic req_type draw_request();
      req_type     r;
      int unsigned pick, k, f;
      int          n;
      r.first_num  = NumFieldWidth'($urandom);
      r.first_den  = DenFieldWidth'($urandom);
      r.second_num = NumFieldWidth'($urandom);
      r.second_den = DenFieldWidth'($urandom);
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         // one or both denominators zero
         k = $urandom_range(0, 2);
         if (k != 1) r.first_den = '0;
         if (k != 0) r.second_den = '0;
      end else if (pick <= 4) begin
         // small denominators, short gcd chains
         r.first_den  = DenFieldWidth'($urandom_range(1, 64));
         r.second_den = DenFieldWidth'($urandom_range(1, 64));
      end else if (pick <= 8) begin
         // denominators with a common factor
         f = $urandom_range(2, 181);
         r.first_den  = DenFieldWidth'(f * $urandom_range(1, DenMax / f));
         r.second_den = DenFieldWidth'(f * $urandom_range(1, DenMax / f));
      end else if (pick <= 11) begin
         // second fraction cancels the first: -(n*k)/(d*k)
         k = $urandom_range(1, 8);
         n = int'($urandom_range(0, 2 * (DenMax / k))) - int'(DenMax / k);
         r.first_num  = n[NumFieldWidth-1:0];
         r.first_den  = DenFieldWidth'($urandom_range(1, DenMax / k));
         r.second_den = DenFieldWidth'(r.first_den * k);
         n = -n * int'(k);
         r.second_num = n[NumFieldWidth-1:0];
      end
      return r;
   endfunction

   // Drive one request after a random gap and queue its expected sum on accept
   task automatic send_request(req_type r, rsp_type want, int idx);
      int gap;
      gap = ((idx % 300) >= 220) ? 0 : $urandom_range(0, MaxWait);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_sums.push_back(want);
   endtask

   task automatic report_mismatch(string field, longint want, longint got);
      if (fail_count < MaxReports)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      fail_count++;
   endtask

   task automatic check_sum(rsp_type got);
      rsp_type want;
      result_count++;
      if (pending_sums.size() == 0) begin
         if (fail_count < MaxReports)
            $display("%0t: result with no request pending, expected none, got %0d/%0d bad=%0b",
                     $time, got.sum_num, got.sum_den, got.bad_input);
         fail_count++;
         return;
      end
      want = pending_sums.pop_front();
      if (want.bad_input) bad_count++;
      else if (want.sum_num == 0) zero_count++;
      if (got.sum_num !== want.sum_num)
         report_mismatch("sum_num", want.sum_num, got.sum_num);
      if (got.sum_den !== want.sum_den)
         report_mismatch("sum_den", want.sum_den, got.sum_den);
      if (got.bad_input !== want.bad_input)
         report_mismatch("bad_input", want.bad_input, got.bad_input);
   endtask

   // Result side: stalls a random number of valid cycles per result
   initial begin : sum_checker
      int hold;
      do @(posedge clock); while (reset);
      forever begin
         hold = ((result_count % 250) < 60) ? 0 : $urandom_range(0, MaxWait);
         rsp_stall <= (hold != 0);
         forever begin
            @(posedge clock);
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
               check_sum(rsp_data);
               break;
            end
            if (rsp_valid === 1'b1 && hold > 0) begin
               hold--;
               if (hold == 0) rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("%0t: timeout with %0d results pending", $time, pending_sums.size());
         $display("FAIL rational_add_reduce_top");
         $finish;
      end
   end

   initial begin : stimulus
      rsp_type want;
      req_type r;
      int      idx;

      // zero denominators
      add_case(5, 0, 3, 7, 1'b1, 0, 0, 1'b1);
      add_case(3, 7, 5, 0, 1'b1, 0, 0, 1'b1);
      add_case(0, 0, 0, 0, 1'b1, 0, 0, 1'b1);
      add_case(-32768, 0, 32767, 32767, 1'b1, 0, 0, 1'b1);
      // zero sums give 0/1
      add_case(0, 1, 0, 1, 1'b1, 0, 1);
      add_case(1, 2, -1, 2, 1'b1, 0, 1);
      add_case(0, 32767, 0, 5, 1'b1, 0, 1);
      add_case(-7, 3, 7, 3, 1'b1, 0, 1);
      // numerator extremes
      add_case(-32768, 1, -32768, 1, 1'b1, -65536, 1);
      add_case(32767, 1, 32767, 1, 1'b1, 65534, 1);
      add_case(32767, 32767, -32768, 32767, 1'b1, -1, 32767);
      add_case(1, 1, 1, 1, 1'b1, 2, 1);
      add_case(-1, 1, 0, 32767, 1'b1, -1, 1);
      add_case(16384, 16384, 16383, 16383, 1'b1, 2, 1);
      // large coprime denominators, widest outputs
      add_case(32767, 32767, 32767, 32766);
      add_case(-32768, 32766, -32768, 32767);
      add_case(32767, 32766, 32767, 32767);
      add_case(1, 32767, -1, 32766);
      // shared factors and reduction
      add_case(6, 4, 10, 6);
      add_case(21, 14, 15, 10);
      add_case(12345, 16384, -12345, 8192);
      // consecutive Fibonacci denominators: longest gcd chain
      add_case(10946, 28657, -6765, 17711);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      idx = 0;
      foreach (directed_cases[i]) begin
         want = directed_cases[i].known ? directed_cases[i].want
                                        : reduced_sum(directed_cases[i].stim);
         send_request(directed_cases[i].stim, want, idx);
         idx++;
      end

      for (int i = 0; i < RandomItems; i++) begin
         r = draw_request();
         send_request(r, reduced_sum(r), idx);
         idx++;
      end
      req_valid <= 1'b0;

      while (pending_sums.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Ran %0d fraction additions (%0d directed) and checked %0d results,",
               idx, directed_cases.size(), result_count);
      $display("of which %0d flagged a zero denominator and %0d reduced to 0/1.",
               bad_count, zero_count);
      if (fail_count == 0) begin
         $display("PASS rational_add_reduce_top");
      end else begin
         $display("FAIL rational_add_reduce_top");
      end
      $finish;
   end

endmodule : rational_add_reduce_top_tb

`default_nettype wire

// ----- sim.f -----
src/rar_pkg.sv
src/rational_add_reduce_top.sv
bench/rational_add_reduce_top_tb.sv
